>>> src/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg: shared types, constants and helpers for the look-at view matrix
// Fixed-point formats, row codes, the queued item layout and the rounding
// helpers used by the back end.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Fraction bits of the input points and vectors
  localparam int IN_FRAC_BITS = 16;
  // Right shift taking a Q2.30 x input product down to 16 fraction bits
  localparam int SHIFT_BITS = 30 + IN_FRAC_BITS - 16;

  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USER_W = 3;

  // Row codes
  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;

  // Normalisation window bounds on the largest magnitude
  localparam logic [62:0] NRM_R8 = 63'd1 << 38;
  localparam logic [62:0] NRM_R1 = 63'd1 << 30;
  localparam logic [62:0] NRM_L8 = 63'd1 << 21;
  localparam logic [62:0] NRM_L1 = 63'd1 << 29;

  localparam logic [31:0] ONE_Q30 = 32'd1 << 30;
  localparam logic [63:0] SH_HALF = 64'd1 << (SHIFT_BITS - 1);

  // One queued item, forward difference already formed
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] upv;
    logic [2:0][32:0] fmag;
    logic [2:0]       fsgn;
  } lav_item_t;

  // Pick one of three lanes
  function automatic logic signed [31:0] sel3(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic signed [31:0] c,
                                              input logic [1:0] idx);
    logic signed [31:0] r;
    case (idx)
      2'd0:    r = a;
      2'd1:    r = b;
      2'd2:    r = c;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Operand lanes of the cross product, one product per step
  function automatic logic [1:0] cross_p(input logic [2:0] t);
    logic [1:0] r;
    case (t)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_q(input logic [2:0] t);
    logic [1:0] r;
    case (t)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Q4.60 to Q2.30, ties away from zero, clamped to plus or minus one
  function automatic logic signed [31:0] up_round(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    logic [31:0] c;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << 29)) >> 30;
    c   = (r > 64'(ONE_Q30)) ? ONE_Q30 : r[31:0];
    return v[63] ? $signed(-c) : $signed(c);
  endfunction

  // Round the dot product to 16 fraction bits and negate
  function automatic logic [47:0] shift_round(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + SH_HALF) >> SHIFT_BITS;
    return v[63] ? r[47:0] : 48'(-r);
  endfunction

endpackage

>>> src/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix: fixed-point look-at view matrix
// Turns an eye point, a target point and an up vector into three matrix rows.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_*: one transaction carries eye, target and up (nine
//   signed Q16.16 words). Output channel out_*: three transactions per input,
//   side, up and negated forward rows in Q2.30 with the Q32.16 translation
//   term; tlast marks the third row, tuser holds row index and degenerate.
//   The back end works on one item at a time, its time per item set by the
//   bit-serial square root and three-lane divider, each run once for forward
//   and once for side; a degenerate item finishes earlier. The front queue
//   holds two items, so input transactions are taken while the back end
//   works.
//   Reset (rst_n low, synchronous) empties the queue and the output register.
//   When the receiver stalls, the row waits in the output register and the
//   back end holds before the next row; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upward_x, upward_y,
  // upward_z, 32 bits each from bit 0
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // row_x [31:0], row_y [63:32], row_z [95:64], row_shift [143:96]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // row_index [1:0], degenerate [2]
  output logic [OUT_USER_W-1:0] out_tuser,
  // last_row
  output logic                  out_tlast
);

  lav_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  lav_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  lav_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> src/lav_front.sv
// ----------------------------------------------------------------------------
// lav_front: input stage and item queue
// Accepts input transactions, forms the forward difference with its signs
// and magnitudes, and holds up to two items for the back end.
// ----------------------------------------------------------------------------
module lav_front import lav_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 q_valid,
  output lav_item_t            q_item,
  input  logic                 q_pop
);

  lav_item_t  item;
  lav_item_t  mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic signed [32:0] diff [3];

  // Unpack and form target - eye at 33 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item.eye[i] = in_tdata[32*i +: 32];
      item.upv[i] = in_tdata[32*(i+6) +: 32];
      diff[i]     = $signed({in_tdata[32*(i+3)+31], in_tdata[32*(i+3) +: 32]})
                  - $signed({in_tdata[32*i+31], in_tdata[32*i +: 32]});
      item.fsgn[i] = diff[i][32];
      item.fmag[i] = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = mem_r[rp_r];

  // Store incoming items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> src/lav_sqrt.sv
// ----------------------------------------------------------------------------
// lav_sqrt: bit-serial integer square root
// Floor square root of a 62-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module lav_sqrt import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] x,
  output logic        done,
  output logic [30:0] root
);

  logic [61:0] xs_r;
  logic [33:0] rem_r;
  logic [30:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [33:0] rem_try;
  logic [33:0] trial;

  assign rem_try = {rem_r[31:0], xs_r[61:60]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign done    = done_r;
  assign root    = root_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One root digit a step
  always_ff @(posedge clk) begin
    if (start) begin
      xs_r   <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      xs_r <= {xs_r[59:0], 2'b00};
      if (rem_try >= trial) begin
        rem_r  <= rem_try - trial;
        root_r <= {root_r[29:0], 1'b1};
      end else begin
        rem_r  <= rem_try;
        root_r <= {root_r[29:0], 1'b0};
      end
    end
  end

endmodule

>>> src/lav_div.sv
// ----------------------------------------------------------------------------
// lav_div: three-lane restoring divider
// Computes round(a * 2^30 / n) for three magnitudes sharing one divisor,
// one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module lav_div import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] a [3],
  input  logic [30:0] n,
  output logic        done,
  output logic [30:0] q [3]
);

  logic [31:0] rem_r [3];
  logic [30:0] lo_r  [3];
  logic [30:0] q_r   [3];
  logic [30:0] n_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [60:0] num   [3];
  logic [31:0] t     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, a[i], 30'd0} + 61'(n[30:1]);
      t[i]   = {rem_r[i][30:0], lo_r[i][30]};
      q[i]   = q_r[i];
    end
  end

  assign done = done_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift, compare and subtract in every lane
  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= n;
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= {2'b00, num[i][60:31]};
        lo_r[i]  <= num[i][30:0];
        q_r[i]   <= '0;
      end
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= {lo_r[i][29:0], 1'b0};
        if (t[i] >= {1'b0, n_r}) begin
          rem_r[i] <= t[i] - {1'b0, n_r};
          q_r[i]   <= {q_r[i][29:0], 1'b1};
        end else begin
          rem_r[i] <= t[i];
          q_r[i]   <= {q_r[i][29:0], 1'b0};
        end
      end
    end
  end

endmodule

>>> src/lav_back.sv
// ----------------------------------------------------------------------------
// lav_back: matrix sequencer and output register
// Normalises forward and side, forms the cross products and dot products on
// one shared multiplier, and presents three row transactions.
// ----------------------------------------------------------------------------
module lav_back import lav_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  lav_item_t             q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAX   = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_CROSS = 4'd6;
  localparam logic [3:0] S_XFER  = 4'd7;
  localparam logic [3:0] S_DOT   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]  state_r;
  logic [2:0]  cnt_r;
  logic [1:0]  row_r;
  logic        vph_r;
  logic        degen_r;

  logic signed [31:0] eye_r [3];
  logic signed [31:0] upv_r [3];
  logic signed [31:0] fn_r  [3];
  logic signed [31:0] sn_r  [3];
  logic signed [31:0] un_r  [3];
  logic [62:0]        va_r  [3];
  logic [2:0]         sg_r;
  logic [62:0]        m_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] tmp_r;
  logic signed [63:0] cres_r [3];

  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] va32 [3];
  logic signed [31:0] rowv [3];
  logic signed [31:0] pv   [3];
  logic signed [31:0] qv   [3];
  logic [62:0]        vmax;
  logic signed [63:0] acc_add;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [30:0]        sqrt_root;
  logic               div_start;
  logic               div_done;
  logic [29:0]        div_a [3];
  logic [30:0]        div_q [3];
  logic               emit_ok;

  // Lane views of the working vectors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va32[i]  = $signed({2'b00, va_r[i][29:0]});
      div_a[i] = va_r[i][29:0];
      pv[i]    = vph_r ? sn_r[i] : fn_r[i];
      qv[i]    = vph_r ? fn_r[i] : upv_r[i];
      if (degen_r) begin
        rowv[i] = '0;
      end else begin
        case (row_r)
          ROW_SIDE: rowv[i] = sn_r[i];
          ROW_UP:   rowv[i] = un_r[i];
          default:  rowv[i] = -fn_r[i];
        endcase
      end
    end
    vmax = va_r[0];
    if (va_r[1] > vmax) vmax = va_r[1];
    if (va_r[2] > vmax) vmax = va_r[2];
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ: begin
        mul_a = sel3(va32[0], va32[1], va32[2], cnt_r[1:0]);
        mul_b = mul_a;
      end
      S_CROSS: begin
        mul_a = sel3(pv[0], pv[1], pv[2], cross_p(cnt_r));
        mul_b = sel3(qv[0], qv[1], qv[2], cross_q(cnt_r));
      end
      S_DOT: begin
        mul_a = sel3(rowv[0], rowv[1], rowv[2], cnt_r[1:0]);
        mul_b = sel3(eye_r[0], eye_r[1], eye_r[2], cnt_r[1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_add    = (cnt_r == 3'd1) ? prod_r : acc_r + prod_r;
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign sqrt_start = (state_r == S_SQ) && (cnt_r == 3'd3);
  assign div_start  = (state_r == S_SQRT) && sqrt_done;
  assign emit_ok    = !out_v_r || out_tready;

  lav_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (acc_add[61:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  lav_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .n     (sqrt_root),
    .done  (div_done),
    .q     (div_q)
  );

  // Shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      row_r   <= ROW_SIDE;
      vph_r   <= 1'b0;
      degen_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            vph_r   <= 1'b0;
            degen_r <= 1'b0;
            row_r   <= ROW_SIDE;
            state_r <= S_MAX;
          end
        end
        S_MAX: begin
          cnt_r <= '0;
          if (vmax == '0) begin
            degen_r <= 1'b1;
            state_r <= S_DOT;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_r < NRM_R1 && m_r >= NRM_L1) begin
            cnt_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cnt_r   <= '0;
            state_r <= S_CROSS;
          end
        end
        S_CROSS: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd6) begin
            state_r <= S_XFER;
          end
        end
        S_XFER: begin
          cnt_r <= '0;
          if (!vph_r) begin
            vph_r   <= 1'b1;
            state_r <= S_MAX;
          end else begin
            state_r <= S_DOT;
          end
        end
        S_DOT: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            cnt_r <= '0;
            if (row_r == ROW_FWD) begin
              state_r <= S_IDLE;
            end else begin
              row_r   <= row_r + 2'd1;
              state_r <= S_DOT;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          eye_r[i] <= $signed(q_item.eye[i]);
          upv_r[i] <= $signed(q_item.upv[i]);
          va_r[i]  <= {30'd0, q_item.fmag[i]};
        end
        sg_r <= q_item.fsgn;
      end
      S_MAX: begin
        m_r <= vmax;
      end
      S_NORM: begin
        // Bring the largest magnitude into [2^29, 2^30)
        if (m_r >= NRM_R8) begin
          m_r <= m_r >> 8;
          for (int i = 0; i < 3; i++) va_r[i] <= va_r[i] >> 8;
        end else if (m_r >= NRM_R1) begin
          m_r <= m_r >> 1;
          for (int i = 0; i < 3; i++) va_r[i] <= va_r[i] >> 1;
        end else if (m_r < NRM_L8) begin
          m_r <= m_r << 8;
          for (int i = 0; i < 3; i++) va_r[i] <= va_r[i] << 8;
        end else if (m_r < NRM_L1) begin
          m_r <= m_r << 1;
          for (int i = 0; i < 3; i++) va_r[i] <= va_r[i] << 1;
        end
      end
      S_SQ: begin
        if (cnt_r != 3'd0) begin
          acc_r <= acc_add;
        end
      end
      S_DIV: begin
        // Apply the original signs to the unit vector
        if (div_done) begin
          for (int i = 0; i < 3; i++) begin
            if (!vph_r) begin
              fn_r[i] <= sg_r[i] ? -$signed({1'b0, div_q[i]}) : $signed({1'b0, div_q[i]});
            end else begin
              sn_r[i] <= sg_r[i] ? -$signed({1'b0, div_q[i]}) : $signed({1'b0, div_q[i]});
            end
          end
        end
      end
      S_CROSS: begin
        case (cnt_r)
          3'd1, 3'd3, 3'd5: tmp_r <= prod_r;
          3'd2: cres_r[0] <= tmp_r - prod_r;
          3'd4: cres_r[1] <= tmp_r - prod_r;
          3'd6: cres_r[2] <= tmp_r - prod_r;
          default: tmp_r <= tmp_r;
        endcase
      end
      S_XFER: begin
        for (int i = 0; i < 3; i++) begin
          if (!vph_r) begin
            va_r[i] <= cres_r[i][63] ? 63'(-cres_r[i]) : 63'(cres_r[i]);
            sg_r[i] <= cres_r[i][63];
          end else begin
            un_r[i] <= up_round(cres_r[i]);
          end
        end
      end
      S_DOT: begin
        if (cnt_r != 3'd0) begin
          acc_r <= acc_add;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  // Output register: load a row, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (state_r == S_EMIT && emit_ok) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && emit_ok) begin
      out_data_r <= {shift_round(acc_r), rowv[2], rowv[1], rowv[0]};
      out_user_r <= {degen_r, row_r};
      out_last_r <= (row_r == ROW_FWD);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

>>> src/lav_check.sv
// ----------------------------------------------------------------------------
// lav_check: port-level checks for the look-at view matrix
// Watches both channels: input data, row order, degenerate rows.
// ----------------------------------------------------------------------------
module lav_check import lav_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  // Accepted input transactions carry known data
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown(in_tdata))
    else $error("unknown input data accepted");

  // Hold a stalled row
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("row changed while stalled");

  // Last flag only on the negated forward row
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser[1:0] == ROW_FWD)))
    else $error("tlast does not match row index");

  // Degenerate rows carry zeros
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == '0)
    else $error("degenerate row not zero");

  // Rows follow side, up, forward
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid |->
      out_tuser[1:0] == $past(out_tuser[1:0]) + 2'd1)
    else $error("row order broken");

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);

>>> tb/lav_checker.sv
// ----------------------------------------------------------------------------
// lav_checker: row predictor and comparator for the look-at view matrix
// Watches both channels, works out the three expected rows for every input
// transaction and compares each output transaction with the oldest one.
// ----------------------------------------------------------------------------
module lav_checker import lav_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    rows_pending
);

  typedef struct packed {
    logic [47:0] shift;
    logic [31:0] rz;
    logic [31:0] ry;
    logic [31:0] rx;
    logic [1:0]  idx;
    logic        last;
    logic        degen;
  } view_row_t;

  view_row_t row_queue[$];

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale to a common window, then divide each magnitude by the length
  function automatic bit unit_vec(input longint v[3], output longint r[3]);
    longint unsigned a[3], m, sum, n;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = abs64(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      m = ((a[i] << 30) + n / 2) / n;
      r[i] = (v[i] < 0) ? -longint'(m) : longint'(m);
    end
    return 1;
  endfunction

  function automatic longint round_away(longint x, int s);
    longint unsigned m;
    m = (abs64(x) + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void cross_vec(input longint p[3], input longint q[3],
                                    output longint c[3]);
    c[0] = p[1] * q[2] - p[2] * q[1];
    c[1] = p[2] * q[0] - p[0] * q[2];
    c[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  // Work out the three view rows of one input transaction
  task automatic predict_rows(input logic [IN_DATA_W-1:0] d);
    longint eye[3], fwd[3], upv[3], fn[3], sd[3], sn[3], uc[3], u, dot;
    longint rows[3][3];
    bit degen;
    view_row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(d[32*i +: 32]));
      fwd[i] = longint'($signed(d[32*(3+i) +: 32])) - eye[i];
      upv[i] = longint'($signed(d[32*(6+i) +: 32]));
      for (int k = 0; k < 3; k++) rows[k][i] = 0;
    end
    degen = 0;
    if (!unit_vec(fwd, fn)) begin
      degen = 1;
    end else begin
      cross_vec(fn, upv, sd);
      if (!unit_vec(sd, sn)) begin
        degen = 1;
      end else begin
        cross_vec(sn, fn, uc);
        for (int i = 0; i < 3; i++) begin
          u = round_away(uc[i], 30);
          if (u > (64'sd1 <<< 30)) u = 64'sd1 <<< 30;
          if (u < -(64'sd1 <<< 30)) u = -(64'sd1 <<< 30);
          rows[0][i] = sn[i];
          rows[1][i] = u;
          rows[2][i] = -fn[i];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      dot = 0;
      for (int i = 0; i < 3; i++) dot += rows[k][i] * eye[i];
      r.shift = 48'(-round_away(dot, SHIFT_BITS));
      r.rx    = 32'(rows[k][0]);
      r.ry    = 32'(rows[k][1]);
      r.rz    = 32'(rows[k][2]);
      r.idx   = (k == 0) ? ROW_SIDE : (k == 1) ? ROW_UP : ROW_FWD;
      r.last  = (k == 2);
      r.degen = degen;
      row_queue.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("row mismatch: %s got %h want %h", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    view_row_t w;
    if (rst_n && in_tvalid && in_tready) predict_rows(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (row_queue.size() == 0) begin
        report_mismatch("unexpected row", out_tdata[63:0], 64'd0);
      end else begin
        w = row_queue.pop_front();
        if (out_tdata[31:0] !== w.rx) report_mismatch("row_x", out_tdata[31:0], w.rx);
        if (out_tdata[63:32] !== w.ry) report_mismatch("row_y", out_tdata[63:32], w.ry);
        if (out_tdata[95:64] !== w.rz) report_mismatch("row_z", out_tdata[95:64], w.rz);
        if (out_tdata[143:96] !== w.shift)
          report_mismatch("row_shift", out_tdata[143:96], w.shift);
        if (out_tuser[1:0] !== w.idx) report_mismatch("row_index", out_tuser[1:0], w.idx);
        if (out_tuser[2] !== w.degen) report_mismatch("degenerate", out_tuser[2], w.degen);
        if (out_tlast !== w.last) report_mismatch("last_row", out_tlast, w.last);
      end
    end
    // Publish the number of rows still owed
    rows_pending = row_queue.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the look-at view matrix
// Drives directed and random eye, target and up vectors under varying
// back-pressure; the checker predicts and compares every row.
// ----------------------------------------------------------------------------
module tb;
  import lav_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // eye_x..z, target_x..z, upward_x..z, 32 bits each from bit 0
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // row_x, row_y, row_z, row_shift
  logic [OUT_DATA_W-1:0] out_tdata;
  // row_index, degenerate
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  int                    fail_count;
  int                    rows_pending;
  int                    cycle_count = 0;
  int                    send_idle_pct;
  int                    recv_idle_pct;

  localparam int CYCLE_LIMIT = 900000;

  look_at_view_matrix dut (.*);

  lav_checker checker_i (.*);

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 255)) : -32'($urandom_range(1, 255));
      3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Present one transaction and hold it until taken; drop valid only to idle
  task automatic send_view(input logic [31:0] w[9]);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    for (int i = 0; i < 9; i++) in_tdata[32*i +: 32] <= w[i];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic [31:0] w[9];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) w[i] = rand_word();
      // Occasionally collapse forward, make up parallel to forward or zero it
      case ($urandom_range(19))
        0: for (int i = 0; i < 3; i++) w[3+i] = w[i];
        1: for (int i = 0; i < 3; i++) w[6+i] = w[3+i] - w[i];
        2: for (int i = 0; i < 3; i++) w[6+i] = 32'd0;
        default: ;
      endcase
      send_view(w);
    end
  endtask

  // Stop sending and wait for every owed row
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] w[9];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: standard view, looking at self, up along forward, zero up, extremes
    w = '{0, 0, 32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000, 0};
    send_view(w);
    w = '{32'h0001_0000, 2, 3, 32'h0001_0000, 2, 3, 0, 32'h0001_0000, 0};
    send_view(w);
    w = '{0, 0, 0, 0, 32'h0003_0000, 0, 0, 32'h0001_0000, 0};
    send_view(w);
    w = '{1, 2, 3, 4, 5, 6, 0, 0, 0};
    send_view(w);
    w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_view(w);
    w = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_view(w);
    w = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_view(w);
    w = '{0, 0, 0, 32'hffff_ffff, 1, 0, 0, 0, 32'hffff_ffff};
    send_view(w);
    w = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 32'h0001_0000,
          32'h8000_0000, 0, 0};
    send_view(w);
    send_random(12);
    // Hold off until the pipe is empty
    wait_drained();

    send_idle_pct = 17;
    recv_idle_pct = 73;
    send_random(130);
    wait_drained();
    send_idle_pct = 73;
    recv_idle_pct = 17;
    send_random(130);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(140);
    wait_drained();
    repeat (400) @(posedge clk);

    if (fail_count == 0 && rows_pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
src/lav_pkg.sv
src/lav_front.sv
src/lav_sqrt.sv
src/lav_div.sv
src/lav_back.sv
src/look_at_view_matrix.sv
src/lav_check.sv
tb/lav_checker.sv
tb/tb.sv
